// ===== design/pba_pkg.sv =====
// Shared constants, request codes and controller/datapath interface types for the page allocator.
package pba_pkg;

    localparam int ADDR_W   = 23;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int WORD_W   = 8;
    localparam int WORD_LOG = 3;

    localparam logic [FUNC_W-1:0] FUNC_RESERVE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UNRESERVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC     = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic                clear;
        logic                load;
        logic                fill_go;
        logic                scan_go;
        logic                finish;
        logic                ret_page;
        logic [STATUS_W-1:0] code;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic div_done;
        logic is_range;
        logic is_alloc;
        logic bad;
        logic alloc_zero;
        logic alloc_big;
        logic fill_done;
        logic found;
        logic scan_end;
    } stat_t;

endpackage

// ===== design/page_bitmap_first_fit_allocator_unit.sv =====
// Top level of the first-fit page bitmap allocator.
//
//   Channel   Handshake          Payload
//   request   start / busy       func, start_addr, stop_addr, size_bytes
//   result    done (strobe)      status, first_page
//
// A request is taken when start is high and busy is low; one result follows per request.
// Every request passes through the page dividers, then a check state. Valid range requests then
// walk the covered map rows, one 8-page row per cycle; valid allocate requests scan rows from
// the bottom, pass through a found state on a hit and clear the found run like a range
// request. done is registered and rises in the cycle after the last step.
// After reset a clearing pass writes NUM_PAGES/8 rows with busy high; done cannot be stalled.
module page_bitmap_first_fit_allocator_unit #(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pba_pkg::FUNC_W-1:0]   func,
    input  logic [pba_pkg::ADDR_W-1:0]   start_addr,
    input  logic [pba_pkg::ADDR_W-1:0]   stop_addr,
    input  logic [pba_pkg::ADDR_W-1:0]   size_bytes,
    output logic                         done,
    output logic [pba_pkg::STATUS_W-1:0] status,
    output logic [$clog2(NUM_PAGES)-1:0] first_page
);

    pba_pkg::cmd_t  cmd;
    pba_pkg::stat_t stat;

    pba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    pba_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .func       (func),
        .start_addr (start_addr),
        .stop_addr  (stop_addr),
        .size_bytes (size_bytes),
        .done       (done),
        .status     (status),
        .first_page (first_page)
    );

endmodule

// ===== design/pba_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module pba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pba_div.sv =====
// Reciprocal-multiply divider of an address by a constant page size, with a remainder flag.
module pba_div #(
    parameter int DIVISOR = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [pba_pkg::ADDR_W-1:0] dividend,
    output logic [pba_pkg::ADDR_W-1:0] quot,
    output logic                       rem_nz,
    output logic                       done
);

    localparam int AW     = pba_pkg::ADDR_W;
    localparam int SHIFT  = AW + $clog2(DIVISOR);
    localparam int MUL_W  = AW + 1;
    localparam int PROD_W = AW + MUL_W;
    localparam int DIV_W  = $clog2(DIVISOR) + 1;
    localparam int BACK_W = AW + DIV_W;
    localparam logic [MUL_W-1:0] RECIP =
        MUL_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic              stage1_reg, stage1_next;
    logic              stage2_reg, stage2_next;
    logic              done_reg, done_next;
    logic [AW-1:0]     num_reg, num_next;
    logic [AW-1:0]     quot_reg, quot_next;
    logic              rem_nz_reg, rem_nz_next;
    logic [PROD_W-1:0] prod;
    logic [BACK_W-1:0] back;

    always_comb
    begin
        prod        = PROD_W'(num_reg) * PROD_W'(RECIP);
        back        = BACK_W'(quot_reg) * BACK_W'(DIVISOR);
        stage1_next = go;
        stage2_next = stage1_reg;
        done_next   = stage2_reg;
        num_next    = go ? dividend : num_reg;
        quot_next   = stage1_reg ? AW'(prod >> SHIFT) : quot_reg;
        rem_nz_next = stage2_reg ? (back[AW-1:0] != num_reg) : rem_nz_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            stage2_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            stage1_reg <= stage1_next;
            stage2_reg <= stage2_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        quot_reg   <= quot_next;
        rem_nz_reg <= rem_nz_next;
    end

    assign quot   = quot_reg;
    assign rem_nz = rem_nz_reg;
    assign done   = done_reg;

endmodule

// ===== design/pba_ctrl.sv =====
// Controller state machine that sequences clearing, division, map walks and results.
module pba_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  pba_pkg::stat_t stat,
    output pba_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_FOUND = 7'b0100000,
        S_FILL  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.is_range)
                begin
                    if (stat.bad)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = pba_pkg::STATUS_BAD;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.fill_go = 1'b1;
                        state_next  = S_FILL;
                    end
                end
                else if (stat.is_alloc)
                begin
                    if (stat.alloc_zero)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = pba_pkg::STATUS_DONE;
                        state_next = S_IDLE;
                    end
                    else if (stat.alloc_big)
                    begin
                        cmd.finish = 1'b1;
                        cmd.code   = pba_pkg::STATUS_FULL;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_go = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
                else
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = pba_pkg::STATUS_BAD;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (stat.found)
                begin
                    state_next = S_FOUND;
                end
                else if (stat.scan_end)
                begin
                    cmd.finish = 1'b1;
                    cmd.code   = pba_pkg::STATUS_FULL;
                    state_next = S_IDLE;
                end
            end
            S_FOUND:
            begin
                cmd.fill_go = 1'b1;
                state_next  = S_FILL;
            end
            S_FILL:
            begin
                if (stat.fill_done)
                begin
                    cmd.finish   = 1'b1;
                    cmd.ret_page = stat.is_alloc;
                    cmd.code     = pba_pkg::STATUS_DONE;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ===== design/pba_dp.sv =====
// Datapath with the page map memory, page dividers, row walker and result registers.
module pba_dp #(
    parameter int NUM_PAGES  = 1024,
    parameter int PAGE_BYTES = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pba_pkg::cmd_t                cmd,
    output pba_pkg::stat_t               stat,
    input  logic [pba_pkg::FUNC_W-1:0]   func,
    input  logic [pba_pkg::ADDR_W-1:0]   start_addr,
    input  logic [pba_pkg::ADDR_W-1:0]   stop_addr,
    input  logic [pba_pkg::ADDR_W-1:0]   size_bytes,
    output logic                         done,
    output logic [pba_pkg::STATUS_W-1:0] status,
    output logic [$clog2(NUM_PAGES)-1:0] first_page
);

    localparam int AW     = pba_pkg::ADDR_W;
    localparam int WW     = pba_pkg::WORD_W;
    localparam int LW     = pba_pkg::WORD_LOG;
    localparam int PAGE_W = $clog2(NUM_PAGES);
    localparam int ROWS   = (NUM_PAGES + WW - 1) / WW;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W  = ROW_W + LW;
    localparam int RUN_W  = $clog2(NUM_PAGES + 1);
    localparam int RGN_W  = 33;
    localparam logic [RGN_W-1:0] REGION = RGN_W'(NUM_PAGES) * RGN_W'(PAGE_BYTES);

    logic [pba_pkg::FUNC_W-1:0] func_reg;
    logic                       bad_reg;
    logic [IDX_W-1:0]           lo_reg;
    logic [IDX_W-1:0]           hi_reg;
    logic [AW-1:0]              pages_reg;
    logic [RUN_W-1:0]           run_reg;
    logic                       fill_val_reg;
    logic                       mode_scan_reg;
    logic [ROW_W-1:0]           rd_row_reg;
    logic [ROW_W-1:0]           rd_last_reg;
    logic [ROW_W-1:0]           pend_row_reg;
    logic                       rd_active_reg;
    logic                       pend_reg;
    logic [ROW_W-1:0]           clr_row_reg;
    logic                       done_reg;
    logic [pba_pkg::STATUS_W-1:0] status_reg;
    logic [PAGE_W-1:0]          first_page_reg;

    logic [AW-1:0]    div_a_in;
    logic [AW-1:0]    stop_clamp;
    logic             bad_in;
    logic [AW-1:0]    qa;
    logic [AW-1:0]    qb;
    logic             ra_nz;
    logic             da_done;
    logic             db_done;
    logic             div_done;

    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [WW-1:0]    wdata;
    logic [WW-1:0]    rd_data;
    logic [WW-1:0]    fill_word;

    logic [RUN_W-1:0] run_c;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             scan_hit;
    logic             fill_last;
    logic             scan_last;

    always_comb
    begin
        div_a_in   = (func == pba_pkg::FUNC_ALLOC) ? size_bytes : start_addr;
        stop_clamp = (RGN_W'(stop_addr) > REGION) ? REGION[AW-1:0] : stop_addr;
        bad_in     = (start_addr >= stop_addr) || (RGN_W'(start_addr) >= REGION);
    end

    pba_div #(
        .DIVISOR (PAGE_BYTES)
    ) u_div_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.load),
        .dividend (div_a_in),
        .quot     (qa),
        .rem_nz   (ra_nz),
        .done     (da_done)
    );

    pba_div #(
        .DIVISOR (PAGE_BYTES)
    ) u_div_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.load),
        .dividend (stop_clamp),
        .quot     (qb),
        .rem_nz   (),
        .done     (db_done)
    );

    assign div_done = da_done && db_done;

    // Run length of free pages is carried across rows; pages past the map never count as free.
    always_comb
    begin
        logic [IDX_W-1:0] idx;
        logic             free;
        run_c   = run_reg;
        hit     = 1'b0;
        hit_idx = '0;
        for (int j = 0; j < WW; j++)
        begin
            idx   = {pend_row_reg, LW'(j)};
            free  = rd_data[j] && ({1'b0, idx} < (IDX_W + 1)'(NUM_PAGES));
            run_c = free ? (run_c + RUN_W'(1)) : '0;
            if (!hit && (run_c == pages_reg[RUN_W-1:0]))
            begin
                hit     = 1'b1;
                hit_idx = idx;
            end
        end
    end

    always_comb
    begin
        logic [IDX_W-1:0] idx;
        for (int j = 0; j < WW; j++)
        begin
            idx          = {pend_row_reg, LW'(j)};
            fill_word[j] = ((idx >= lo_reg) && (idx <= hi_reg)) ? fill_val_reg : rd_data[j];
        end
    end

    always_comb
    begin
        scan_hit  = pend_reg && mode_scan_reg && hit;
        fill_last = pend_reg && !mode_scan_reg && (pend_row_reg == rd_last_reg);
        scan_last = pend_reg && mode_scan_reg && (pend_row_reg == rd_last_reg) && !hit;
        if (cmd.clear)
        begin
            we    = 1'b1;
            waddr = clr_row_reg;
            wdata = '1;
        end
        else
        begin
            we    = pend_reg && !mode_scan_reg;
            waddr = pend_row_reg;
            wdata = fill_word;
        end
    end

    pba_ram #(
        .WIDTH (WW),
        .DEPTH (ROWS)
    ) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_row_reg),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_active_reg <= 1'b0;
            pend_reg      <= 1'b0;
            clr_row_reg   <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.clear)
            begin
                clr_row_reg <= clr_row_reg + ROW_W'(1);
            end
            if (cmd.fill_go || cmd.scan_go)
            begin
                rd_active_reg <= 1'b1;
                pend_reg      <= 1'b0;
            end
            else if (scan_hit)
            begin
                rd_active_reg <= 1'b0;
                pend_reg      <= 1'b0;
            end
            else
            begin
                pend_reg <= rd_active_reg;
                if (rd_active_reg && (rd_row_reg == rd_last_reg))
                begin
                    rd_active_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_row_reg <= rd_row_reg;
        if (cmd.load)
        begin
            func_reg <= func;
            bad_reg  <= bad_in;
        end
        if (div_done)
        begin
            lo_reg    <= IDX_W'(qa);
            hi_reg    <= (qb > AW'(NUM_PAGES - 1)) ? IDX_W'(NUM_PAGES - 1) : IDX_W'(qb);
            pages_reg <= qa + AW'(ra_nz);
        end
        else if (scan_hit)
        begin
            lo_reg <= hit_idx + IDX_W'(1) - IDX_W'(pages_reg);
            hi_reg <= hit_idx;
        end
        if (cmd.fill_go)
        begin
            rd_row_reg    <= lo_reg[IDX_W-1:LW];
            rd_last_reg   <= hi_reg[IDX_W-1:LW];
            mode_scan_reg <= 1'b0;
            fill_val_reg  <= (func_reg == pba_pkg::FUNC_UNRESERVE);
        end
        else if (cmd.scan_go)
        begin
            rd_row_reg    <= '0;
            rd_last_reg   <= ROW_W'(ROWS - 1);
            mode_scan_reg <= 1'b1;
            run_reg       <= '0;
        end
        else
        begin
            if (rd_active_reg && (rd_row_reg != rd_last_reg))
            begin
                rd_row_reg <= rd_row_reg + ROW_W'(1);
            end
            if (pend_reg && mode_scan_reg)
            begin
                run_reg <= run_c;
            end
        end
        if (cmd.finish)
        begin
            status_reg     <= cmd.code;
            first_page_reg <= cmd.ret_page ? lo_reg[PAGE_W-1:0] : '0;
        end
    end

    always_comb
    begin
        stat            = '0;
        stat.clear_done = (clr_row_reg == ROW_W'(ROWS - 1));
        stat.div_done   = div_done;
        stat.is_range   = (func_reg == pba_pkg::FUNC_RESERVE) ||
                          (func_reg == pba_pkg::FUNC_UNRESERVE);
        stat.is_alloc   = (func_reg == pba_pkg::FUNC_ALLOC);
        stat.bad        = bad_reg;
        stat.alloc_zero = (pages_reg == '0);
        stat.alloc_big  = (pages_reg > AW'(NUM_PAGES));
        stat.fill_done  = fill_last;
        stat.found      = scan_hit;
        stat.scan_end   = scan_last;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign first_page = first_page_reg;

endmodule

// ===== verif/page_bitmap_first_fit_allocator_unit_tb.sv =====
// Self-checking testbench that drives page requests into the allocator and checks every reply.
module page_bitmap_first_fit_allocator_unit_tb;

    localparam int NUM_PAGES     = 1024;
    localparam int PAGE_BYTES    = 4096;
    localparam int REGION_BYTES  = NUM_PAGES * PAGE_BYTES;
    localparam int PAGE_W        = $clog2(NUM_PAGES);
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 400;
    localparam logic [pba_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [pba_pkg::ADDR_W-1:0] ADDR_MAX    = '1;

    typedef struct packed {
        logic [pba_pkg::STATUS_W-1:0] status;
        logic [PAGE_W-1:0]            first_page;
    } reply_t;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [pba_pkg::FUNC_W-1:0]   func;
    logic [pba_pkg::ADDR_W-1:0]   start_addr;
    logic [pba_pkg::ADDR_W-1:0]   stop_addr;
    logic [pba_pkg::ADDR_W-1:0]   size_bytes;
    logic                         done;
    logic [pba_pkg::STATUS_W-1:0] status;
    logic [PAGE_W-1:0]            first_page;

    bit     page_free [NUM_PAGES];
    reply_t predicted_replies [$];
    int     mismatch_count = 0;
    int     cycle_count = 0;

    page_bitmap_first_fit_allocator_unit #(
        .NUM_PAGES (NUM_PAGES),
        .PAGE_BYTES(PAGE_BYTES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .start_addr(start_addr),
        .stop_addr (stop_addr),
        .size_bytes(size_bytes),
        .done      (done),
        .status    (status),
        .first_page(first_page)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic logic [pba_pkg::STATUS_W-1:0] mark_pages(input int lo_addr,
                                                                 input int hi_addr,
                                                                 input bit fill);
        int hi;
        int first_pg;
        int last_pg;
        int p;
        hi = hi_addr;
        if (lo_addr >= hi_addr || lo_addr >= REGION_BYTES)
            return pba_pkg::STATUS_BAD;
        if (hi > REGION_BYTES)
            hi = REGION_BYTES;
        first_pg = lo_addr / PAGE_BYTES;
        last_pg  = hi / PAGE_BYTES;
        if (last_pg > NUM_PAGES - 1)
            last_pg = NUM_PAGES - 1;
        for (p = first_pg; p <= last_pg; p++)
            page_free[p] = fill;
        return pba_pkg::STATUS_DONE;
    endfunction

    function automatic reply_t grab_first_fit(input int nbytes);
        reply_t r;
        int     want;
        int     run_len;
        int     p;
        int     q;
        r.status     = pba_pkg::STATUS_DONE;
        r.first_page = '0;
        want = (nbytes + PAGE_BYTES - 1) / PAGE_BYTES;
        if (want == 0)
            return r;
        r.status = pba_pkg::STATUS_FULL;
        if (want > NUM_PAGES)
            return r;
        run_len = 0;
        for (p = 0; p < NUM_PAGES; p++)
        begin
            run_len = page_free[p] ? run_len + 1 : 0;
            if (run_len == want)
            begin
                for (q = p + 1 - want; q <= p; q++)
                    page_free[q] = 1'b0;
                r.status     = pba_pkg::STATUS_DONE;
                r.first_page = PAGE_W'(p + 1 - want);
                return r;
            end
        end
        return r;
    endfunction

    function automatic reply_t apply_page_request(input logic [pba_pkg::FUNC_W-1:0] f,
                                                  input logic [pba_pkg::ADDR_W-1:0] s,
                                                  input logic [pba_pkg::ADDR_W-1:0] e,
                                                  input logic [pba_pkg::ADDR_W-1:0] sz);
        reply_t r;
        r.status     = pba_pkg::STATUS_BAD;
        r.first_page = '0;
        case (f)
            pba_pkg::FUNC_RESERVE:   r.status = mark_pages(int'(s), int'(e), 1'b0);
            pba_pkg::FUNC_UNRESERVE: r.status = mark_pages(int'(s), int'(e), 1'b1);
            pba_pkg::FUNC_ALLOC:     r = grab_first_fit(int'(sz));
            default:                 r.status = pba_pkg::STATUS_BAD;
        endcase
        return r;
    endfunction

    task automatic send_request(input logic [pba_pkg::FUNC_W-1:0] f,
                                input logic [pba_pkg::ADDR_W-1:0] s,
                                input logic [pba_pkg::ADDR_W-1:0] e,
                                input logic [pba_pkg::ADDR_W-1:0] sz);
        @(negedge clk);
        start      <= 1'b1;
        func       <= f;
        start_addr <= s;
        stop_addr  <= e;
        size_bytes <= sz;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted_replies.push_back(apply_page_request(f, s, e, sz));
    endtask

    task automatic hold_off(input int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    always @(posedge clk)
    begin : check_replies
        reply_t want;
        if (rst_n && done)
        begin
            if (predicted_replies.size() == 0)
                report_mismatch($sformatf("unexpected reply status=%0d first_page=%0d",
                                          status, first_page));
            else
            begin
                want = predicted_replies.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              status, want.status));
                if (first_page !== want.first_page)
                    report_mismatch($sformatf("first_page got %0d want %0d",
                                              first_page, want.first_page));
            end
        end
    end

    task automatic test_edge_cases();
        send_request(pba_pkg::FUNC_ALLOC, '0, '0, '0);
        send_request(pba_pkg::FUNC_ALLOC, '0, '0, 23'd1);
        send_request(pba_pkg::FUNC_ALLOC, '0, '0, 23'd4096);
        send_request(pba_pkg::FUNC_ALLOC, '0, '0, 23'd4097);
        send_request(pba_pkg::FUNC_RESERVE, '0, '0, '0);
        send_request(pba_pkg::FUNC_RESERVE, 23'd100, 23'd50, '0);
        send_request(pba_pkg::FUNC_RESERVE, 23'd4194304, 23'd4194305, '0);
        send_request(pba_pkg::FUNC_UNRESERVE, '0, 23'd4194304, '0);
        send_request(pba_pkg::FUNC_RESERVE, '0, ADDR_MAX, '0);
        send_request(pba_pkg::FUNC_ALLOC, '0, '0, 23'd4096);
        send_request(pba_pkg::FUNC_UNRESERVE, 23'd40960, 23'd81919, '0);
        send_request(pba_pkg::FUNC_ALLOC, '0, '0, 23'd40960);
        send_request(pba_pkg::FUNC_ALLOC, '0, '0, 23'd1);
        send_request(pba_pkg::FUNC_UNRESERVE, 23'd4190208, 23'd4194303, ADDR_MAX);
        send_request(pba_pkg::FUNC_ALLOC, ADDR_MAX, ADDR_MAX, 23'd1);
        send_request(FUNC_UNUSED, 23'd0, 23'd4096, 23'd4096);
        send_request(pba_pkg::FUNC_UNRESERVE, '0, ADDR_MAX, '0);
        send_request(pba_pkg::FUNC_ALLOC, '0, '0, 23'd4194304);
        send_request(pba_pkg::FUNC_UNRESERVE, '0, 23'd4194304, '0);
        send_request(pba_pkg::FUNC_ALLOC, '0, '0, 23'd4194305);
        send_request(pba_pkg::FUNC_ALLOC, '0, '0, ADDR_MAX);
        send_request(pba_pkg::FUNC_RESERVE, 23'd20603, 23'd20680, '0);
        send_request(pba_pkg::FUNC_ALLOC, '0, '0, 23'd24576);
        send_request(pba_pkg::FUNC_RESERVE, 23'd4194303, ADDR_MAX, '0);
        send_request(pba_pkg::FUNC_UNRESERVE, '0, 23'd8192, '0);
    endtask

    task automatic test_mixed_traffic(input int idle_pct, input int count);
        int unsigned                pick;
        int unsigned                base_pg;
        int unsigned                span;
        logic [pba_pkg::FUNC_W-1:0] f;
        logic [pba_pkg::ADDR_W-1:0] s;
        logic [pba_pkg::ADDR_W-1:0] e;
        logic [pba_pkg::ADDR_W-1:0] sz;
        repeat (count)
        begin
            if ($urandom_range(99) < idle_pct)
                hold_off($urandom_range(1, 40));
            pick = $urandom_range(99);
            f  = pba_pkg::FUNC_ALLOC;
            s  = pba_pkg::ADDR_W'($urandom);
            e  = pba_pkg::ADDR_W'($urandom);
            sz = pba_pkg::ADDR_W'($urandom_range(1, 8 * PAGE_BYTES));
            if (pick < 35)
            begin
                if (pick < 3)
                    sz = pba_pkg::ADDR_W'($urandom);
                else if (pick < 5)
                    sz = '0;
            end
            else if (pick < 85)
            begin
                f       = (pick < 60) ? pba_pkg::FUNC_RESERVE : pba_pkg::FUNC_UNRESERVE;
                base_pg = $urandom_range(NUM_PAGES - 1);
                span    = (pick < 60) ? $urandom_range(0, 12) : $urandom_range(0, 48);
                s = pba_pkg::ADDR_W'(base_pg * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1));
                e = pba_pkg::ADDR_W'(s + $urandom_range(1, (span + 1) * PAGE_BYTES));
            end
            else if (pick < 90)
            begin
                f = pba_pkg::FUNC_UNRESERVE;
                s = '0;
                e = pba_pkg::ADDR_W'($urandom_range(REGION_BYTES, ADDR_MAX));
            end
            else
            begin
                f  = pba_pkg::FUNC_W'($urandom_range(3));
                sz = pba_pkg::ADDR_W'($urandom);
            end
            send_request(f, s, e, sz);
        end
    endtask

    task automatic test_pause_until_drained();
        hold_off(1);
        while (predicted_replies.size() != 0)
            @(posedge clk);
        send_request(pba_pkg::FUNC_ALLOC, '0, '0, 23'd12288);
        send_request(pba_pkg::FUNC_UNRESERVE, '0, 23'd4194304, '0);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        func       = '0;
        start_addr = '0;
        stop_addr  = '0;
        size_bytes = '0;
        foreach (page_free[i])
            page_free[i] = 1'b1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_edge_cases();
        test_mixed_traffic(9, 570);
        test_pause_until_drained();
        test_mixed_traffic(47, 570);
        test_pause_until_drained();
        test_mixed_traffic(0, 560);

        hold_off(1);
        while (predicted_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
